@@ rtl/tsag_pkg.sv @@
`default_nettype none

package tsag_pkg;

  localparam int unsigned V4W  = 32;
  localparam int unsigned V6HW = 64;
  localparam int unsigned EntW = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // register map
  typedef enum logic [CfgIdxW-1:0] {
    REG_V4_BASE      = 3'd0,
    REG_V4_MASK      = 3'd1,
    REG_V6_BASE_HIGH = 3'd2,
    REG_V6_BASE_LOW  = 3'd3,
    REG_V6_MASK_HIGH = 3'd4,
    REG_V6_MASK_LOW  = 3'd5
  } cfg_reg_e;

  // address family
  typedef enum logic {
    FAM_V4 = 1'b0,
    FAM_V6 = 1'b1
  } fam_e;

  typedef struct packed {
    logic [V4W-1:0]  v4_base;
    logic [V4W-1:0]  v4_mask;
    logic [V6HW-1:0] v6_base_high;
    logic [V6HW-1:0] v6_base_low;
    logic [V6HW-1:0] v6_mask_high;
    logic [V6HW-1:0] v6_mask_low;
  } cfg_t;

  typedef struct packed {
    logic [V6HW-1:0] addr_high;
    logic [V6HW-1:0] addr_low;
    logic            source_set;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/tsag_cfg.sv @@
`default_nettype none

module tsag_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [tsag_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [tsag_pkg::CfgDataW-1:0] cfg_data_i,
  output tsag_pkg::cfg_t                    cfg_o
);
  import tsag_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_V4_BASE:      cfg_d.v4_base      = cfg_data_i[V4W-1:0];
        REG_V4_MASK:      cfg_d.v4_mask      = cfg_data_i[V4W-1:0];
        REG_V6_BASE_HIGH: cfg_d.v6_base_high = cfg_data_i;
        REG_V6_BASE_LOW:  cfg_d.v6_base_low  = cfg_data_i;
        REG_V6_MASK_HIGH: cfg_d.v6_mask_high = cfg_data_i;
        REG_V6_MASK_LOW:  cfg_d.v6_mask_low  = cfg_data_i;
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/tsag_core.sv @@
`default_nettype none

module tsag_core (
  input  wire tsag_pkg::cfg_t            cfg_i,
  input  wire logic                      mode_i,
  input  wire logic [tsag_pkg::EntW-1:0] entropy_i,
  output tsag_pkg::res_t                 res_o
);
  import tsag_pkg::*;

  // IPv4 path
  logic [V4W-1:0] host4, low4, h4, val4;
  logic           two4;

  // IPv6 path
  logic [V6HW-1:0] host_hi, host_lo, low_hi, low_lo, hi6, lo6, ent64;
  logic            two_hi, two_lo, enough6;

  always_comb begin
    host4 = ~cfg_i.v4_mask;
    two4  = (host4 & (host4 - V4W'(1))) != '0;
    low4  = host4 & (~host4 + V4W'(1));
    h4    = entropy_i & host4;
    val4  = (cfg_i.v4_base & cfg_i.v4_mask) | h4;
    if (two4) begin
      if (h4 == '0) begin
        val4 = val4 | low4;
      end else if (h4 == host4) begin
        val4 = val4 & ~low4;
      end
    end
  end

  always_comb begin
    ent64   = {{(V6HW-EntW){1'b0}}, entropy_i};
    host_hi = ~cfg_i.v6_mask_high;
    host_lo = ~cfg_i.v6_mask_low;
    two_hi  = (host_hi & (host_hi - V6HW'(1))) != '0;
    two_lo  = (host_lo & (host_lo - V6HW'(1))) != '0;
    low_hi  = host_hi & (~host_hi + V6HW'(1));
    low_lo  = host_lo & (~host_lo + V6HW'(1));
    hi6     = cfg_i.v6_base_high & cfg_i.v6_mask_high;
    lo6     = (cfg_i.v6_base_low & cfg_i.v6_mask_low) | (ent64 & host_lo);
    if (host_lo != '0) begin
      enough6 = two_lo || (host_hi != '0);
    end else begin
      enough6 = two_hi;
    end
    if (enough6 && ((hi6 & host_hi) == '0) && ((lo6 & host_lo) == '0)) begin
      if (host_lo != '0) begin
        lo6 = lo6 | low_lo;
      end else begin
        hi6 = hi6 | low_hi;
      end
    end
  end

  always_comb begin
    if (fam_e'(mode_i) == FAM_V6) begin
      res_o.addr_high  = hi6;
      res_o.addr_low   = lo6;
      res_o.source_set = (cfg_i.v6_base_high | cfg_i.v6_base_low) != '0;
    end else begin
      res_o.addr_high  = '0;
      res_o.addr_low   = {{(V6HW-V4W){1'b0}}, val4};
      res_o.source_set = cfg_i.v4_base != '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tunnel_source_address_gen.sv @@
// Path: an input transaction passes the input register, then the result register,
//   before result valid; address logic sits between the two.
// Throughput: 1 transaction per cycle; both stages advance together whenever
//   the result register is empty or being drained.
// Reset: rst_ni async active low; clears valid flags and all config registers
//   to zero. Payload registers are not reset.
`default_nettype none

module tunnel_source_address_gen (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [tsag_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [tsag_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [31:0]                   s_axis_tdata_i,  // [31:0] entropy
  input  wire logic                          s_axis_tuser_i,  // [0] mode (0 v4, 1 v6)
  // result stream
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [127:0]                       m_axis_tdata_o,  // [63:0] addr_high,
                                                              // [127:64] addr_low
  output logic                               m_axis_tuser_o   // [0] source_set
);
  import tsag_pkg::*;

  cfg_t cfg;
  res_t res;

  // stage 1: captured input transaction
  logic            s1_valid_q;
  logic            s1_mode_q;
  logic [EntW-1:0] s1_ent_q;

  // stage 2: result register
  logic            s2_valid_q;
  res_t            s2_res_q;

  logic s2_free, s1_adv, in_acc;

  tsag_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tsag_core u_core (
    .cfg_i     (cfg),
    .mode_i    (s1_mode_q),
    .entropy_i (s1_ent_q),
    .res_o     (res)
  );

  // Result register takes a new value when empty or drained this cycle;
  // stage 1 moves on in the same cycle, so the input side never waits on
  // the output side unless both stages are full and the sink stalls.
  assign s2_free         = !s2_valid_q || m_axis_tready_i;
  assign s1_adv          = s1_valid_q && s2_free;
  assign s_axis_tready_o = !s1_valid_q || s2_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        s1_valid_q <= s_axis_tvalid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q <= s_axis_tuser_i;
      s1_ent_q  <= s_axis_tdata_i;
    end
    if (s1_adv) begin
      s2_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = s2_valid_q;
  assign m_axis_tdata_o  = {s2_res_q.addr_low, s2_res_q.addr_high};
  assign m_axis_tuser_o  = s2_res_q.source_set;

`ifndef SYNTHESIS
  // accepted transaction lands in stage 1
  a_s1_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("stage 1 missed an accepted transaction");

  // stage 1 content moves into the result register when it has room
  a_s2_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> m_axis_tvalid_o)
    else $error("result register missed stage 1 transaction");

  // stalled stage 1 holds its transaction
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_free) |=> (s1_valid_q && $stable(s1_ent_q) && $stable(s1_mode_q)))
    else $error("stage 1 lost data under stall");

  // nothing enters stage 1 when both stages are full and the sink stalls
  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted with pipeline full");
`endif

endmodule

`default_nettype wire
